[src/cubemap_face_to_equirect_address_core_macros.svh]
// ----------------------------------------------------------------------------
// cubemap_face_to_equirect_address_core_macros.svh
// assertion helpers shared by the address core
// ----------------------------------------------------------------------------
`ifndef CUBEMAP_FACE_TO_EQUIRECT_ADDRESS_CORE_MACROS_SVH
`define CUBEMAP_FACE_TO_EQUIRECT_ADDRESS_CORE_MACROS_SVH

// next-cycle implication, checked only out of reset
`define CFER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset as well
`define CFER_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[src/cfer_pkg.sv]
// ----------------------------------------------------------------------------
// cfer_pkg
// shared widths, constants and arctangent table of the address core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfer_pkg;

  localparam int ANG_W   = 27;   // angle, units of pi / 2^24
  localparam int Q_W     = 18;   // normalized coordinate, signed q1.16
  localparam int VEC_W   = 28;   // direction component, signed q3.24
  localparam int QMAG_W  = 17;   // quotient magnitude bits

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 27'sd8388608;
  localparam logic signed [VEC_W-1:0] ONE_Q24      = 28'sd16777216;
  localparam logic signed [17:0]      GAIN_Q16     = 18'sd107922;
  localparam logic signed [Q_W-1:0]   U_MAX        = 18'sd131071;
  localparam logic signed [Q_W-1:0]   U_MIN        = -18'sd131072;

  typedef enum logic [2:0] {
    FACE_REAR   = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_FRONT  = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_TOP    = 3'd4,
    FACE_BOTTOM = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    REG_FACE_SIZE   = 2'd0,
    REG_PANO_WIDTH  = 2'd1,
    REG_PANO_HEIGHT = 2'd2
  } reg_idx_t;

  localparam int TAB_LEN = 28;

  // atan(2^-i) / pi * 2^24, rounded
  localparam logic signed [ANG_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
    27'sd4194304, 27'sd2476042, 27'sd1308273, 27'sd664100, 27'sd333339,
    27'sd166832, 27'sd83436, 27'sd41721, 27'sd20861, 27'sd10430,
    27'sd5215, 27'sd2608, 27'sd1304, 27'sd652, 27'sd326,
    27'sd163, 27'sd81, 27'sd41, 27'sd20, 27'sd10,
    27'sd5, 27'sd3, 27'sd1, 27'sd1, 27'sd0, 27'sd0, 27'sd0, 27'sd0
  };

endpackage

[src/cfer_div.sv]
// ----------------------------------------------------------------------------
// cfer_div
// pipelined restoring divider, (2c - n) / n for both face coordinates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfer_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0]                         in_face,
  input  logic [11:0]                        in_cx,
  input  logic [11:0]                        in_cy,
  input  logic [12:0]                        n,
  output logic                               out_valid,
  output logic [2:0]                         out_face,
  output logic signed [cfer_pkg::Q_W-1:0]    out_qu,
  output logic signed [cfer_pkg::Q_W-1:0]    out_qv
);

  localparam int NST = cfer_pkg::QMAG_W;

  logic [NST:0]                   vld_r;
  logic [2:0]                     face_r [0:NST];
  logic [13:0]                    ru_r   [0:NST];
  logic [13:0]                    rv_r   [0:NST];
  logic [cfer_pkg::QMAG_W-1:0]    qu_r   [0:NST];
  logic [cfer_pkg::QMAG_W-1:0]    qv_r   [0:NST];
  logic [NST:0]                   negu_r, negv_r, satu_r, satv_r;

  logic signed [14:0] du, dv;
  logic [12:0]        mu, mv;

  always_comb begin
    du = $signed({2'b00, in_cx, 1'b0}) - $signed({2'b00, n});
    dv = $signed({2'b00, in_cy, 1'b0}) - $signed({2'b00, n});
    mu = du[14] ? 13'(-du) : du[12:0];
    mv = dv[14] ? 13'(-dv) : dv[12:0];
  end

  // sign, magnitude and saturation of the numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face_r[0] <= in_face;
      ru_r[0]   <= {1'b0, mu};
      rv_r[0]   <= {1'b0, mv};
      qu_r[0]   <= '0;
      qv_r[0]   <= '0;
      negu_r[0] <= du[14];
      negv_r[0] <= dv[14];
      satu_r[0] <= {1'b0, mu} >= {n, 1'b0};
      satv_r[0] <= {1'b0, mv} >= {n, 1'b0};
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= NST; k++) begin : g_stage
    logic [13:0] cu, cv;
    logic        geu, gev;

    always_comb begin
      cu  = (k == 1) ? ru_r[k-1] : {ru_r[k-1][12:0], 1'b0};
      cv  = (k == 1) ? rv_r[k-1] : {rv_r[k-1][12:0], 1'b0};
      geu = cu >= {1'b0, n};
      gev = cv >= {1'b0, n};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        face_r[k] <= face_r[k-1];
        ru_r[k]   <= geu ? cu - {1'b0, n} : cu;
        rv_r[k]   <= gev ? cv - {1'b0, n} : cv;
        qu_r[k]   <= {qu_r[k-1][cfer_pkg::QMAG_W-2:0], geu};
        qv_r[k]   <= {qv_r[k-1][cfer_pkg::QMAG_W-2:0], gev};
        negu_r[k] <= negu_r[k-1];
        negv_r[k] <= negv_r[k-1];
        satu_r[k] <= satu_r[k-1];
        satv_r[k] <= satv_r[k-1];
      end
    end
  end

  logic signed [cfer_pkg::Q_W-1:0] qmu, qmv;

  always_comb begin
    qmu = $signed({1'b0, qu_r[NST]});
    qmv = $signed({1'b0, qv_r[NST]});
    if (satu_r[NST]) out_qu = negu_r[NST] ? cfer_pkg::U_MIN : cfer_pkg::U_MAX;
    else             out_qu = negu_r[NST] ? -qmu : qmu;
    if (satv_r[NST]) out_qv = negv_r[NST] ? cfer_pkg::U_MIN : cfer_pkg::U_MAX;
    else             out_qv = negv_r[NST] ? -qmv : qmv;
  end

  assign out_valid = vld_r[NST];
  assign out_face  = face_r[NST];

endmodule

[src/cfer_cordic.sv]
// ----------------------------------------------------------------------------
// cfer_cordic
// pipelined cordic vectoring, one micro-rotation per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfer_cordic #(
  parameter int STEPS  = 20,
  parameter int W      = 30,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [W-1:0]                 in_x,
  input  logic signed [W-1:0]                 in_y,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic signed [cfer_pkg::ANG_W-1:0]   out_ang,
  output logic signed [W-1:0]                 out_mag,
  output logic [SIDE_W-1:0]                   out_side
);

  logic [STEPS:0]                      vld_r;
  logic [STEPS:0]                      zero_r;
  logic signed [W-1:0]                 x_r    [0:STEPS];
  logic signed [W-1:0]                 y_r    [0:STEPS];
  logic signed [cfer_pkg::ANG_W-1:0]   z_r    [0:STEPS];
  logic [SIDE_W-1:0]                   side_r [0:STEPS];

  // quarter-turn pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (in_x == '0) && (in_y == '0);
      side_r[0] <= in_side;
      if (in_x[W-1] && !in_y[W-1]) begin
        x_r[0] <= in_y;
        y_r[0] <= -in_x;
        z_r[0] <= cfer_pkg::QUARTER_TURN;
      end else if (in_x[W-1]) begin
        x_r[0] <= -in_y;
        y_r[0] <= in_x;
        z_r[0] <= -cfer_pkg::QUARTER_TURN;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [W-1:0] dx, dy;

    always_comb begin
      dx = x_r[i] >>> i;
      dy = y_r[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        side_r[i+1] <= side_r[i];
        if (!y_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + cfer_pkg::ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - cfer_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // the zero vector gives angle and magnitude zero
  assign out_valid = vld_r[STEPS];
  assign out_ang   = zero_r[STEPS] ? '0 : z_r[STEPS];
  assign out_mag   = zero_r[STEPS] ? '0 : x_r[STEPS];
  assign out_side  = side_r[STEPS];

endmodule

[src/cfer_scale.sv]
// ----------------------------------------------------------------------------
// cfer_scale
// angle to pixel scaling, clamping and linear index, with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfer_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic                               in_face_ok,
  input  logic signed [cfer_pkg::ANG_W-1:0]  in_theta,
  input  logic signed [cfer_pkg::ANG_W-1:0]  in_phi,
  input  logic [13:0]                        w,
  input  logic [12:0]                        h,
  output logic                               out_valid,
  output logic [12:0]                        out_px,
  output logic [11:0]                        out_py,
  output logic [24:0]                        out_idx
);

  logic                vld_a_r, vld_b_r, vld_c_r;
  logic [15:0]         rx_a_r;
  logic [14:0]         ry_a_r;
  logic [12:0]         px_b_r;
  logic [11:0]         py_b_r;
  logic [25:0]         pyw_b_r;
  logic [12:0]         px_c_r;
  logic [11:0]         py_c_r;
  logic [24:0]         idx_c_r;

  logic signed [cfer_pkg::ANG_W-1:0] th, ph;
  logic signed [cfer_pkg::VEC_W-1:0] t;
  logic [40:0]         prod_x;
  logic [38:0]         prod_y;
  logic [13:0]         wm1;
  logic [12:0]         hm1;
  logic [12:0]         px_n;
  logic [11:0]         py_n;

  // stage a: scale the angles
  always_comb begin
    th     = in_face_ok ? in_theta : '0;
    ph     = in_face_ok ? in_phi : '0;
    t      = cfer_pkg::VEC_W'(th) + cfer_pkg::ONE_Q24;
    prod_x = t[26:0] * w;
    prod_y = ph[25:0] * h;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_a_r <= (t[cfer_pkg::VEC_W-1] || t == '0) ? '0 : prod_x[40:25];
      ry_a_r <= (ph[cfer_pkg::ANG_W-1] || ph == '0) ? '0 : prod_y[38:24];
    end
  end

  // stage b: clamp to the image, row times stride
  always_comb begin
    wm1  = w - 14'd1;
    hm1  = h - 13'd1;
    px_n = ({2'b00, wm1} < rx_a_r) ? wm1[12:0] : rx_a_r[12:0];
    py_n = ({2'b00, hm1} < ry_a_r) ? hm1[11:0] : ry_a_r[11:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_b_r  <= px_n;
      py_b_r  <= py_n;
      pyw_b_r <= py_n * w;
    end
  end

  // stage c: output register
  always_ff @(posedge clk) begin
    if (en) begin
      px_c_r  <= px_b_r;
      py_c_r  <= py_b_r;
      idx_c_r <= 25'({13'd0, px_b_r} + pyw_b_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  assign out_valid = vld_c_r;
  assign out_px    = px_c_r;
  assign out_py    = py_c_r;
  assign out_idx   = idx_c_r;

endmodule

[src/cubemap_face_to_equirect_address_core.sv]
// ----------------------------------------------------------------------------
// cubemap_face_to_equirect_address_core
// path, input to result: divider, direction register, theta cordic, gain fix, phi cordic, scale
// throughput: one transfer per cycle; the pipeline moves as one and halts
//   only while a finished result waits on out_tready
// reset: synchronous rst_n clears all valid bits and loads the registers
//   with face 512, width 2048, height 1024
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cubemap_face_to_equirect_address_core_macros.svh"

module cubemap_face_to_equirect_address_core #(
  parameter int MAX_PANO_WIDTH = 8192,
  parameter int CORDIC_STEPS   = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  // face pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // face[2:0], cube_x[14:3], cube_y[26:15], zero pad
  // panorama address output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // pano_x[12:0], pano_y[24:13], pano_index[49:25], pad
);

  localparam int WLIM = (MAX_PANO_WIDTH < 8192) ? MAX_PANO_WIDTH : 8192;
  localparam int ANG_W = cfer_pkg::ANG_W;
  localparam int VEC_W = cfer_pkg::VEC_W;
  localparam int Q_W   = cfer_pkg::Q_W;
  localparam int C1_W  = 30;   // theta cordic datapath
  localparam int C2_W  = 32;   // phi cordic datapath

  // ---------------------------------------------------------------- config
  logic [12:0] face_size_r;
  logic [13:0] pano_width_r;
  logic [12:0] pano_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_size_r   <= 13'd512;
      pano_width_r  <= 14'd2048;
      pano_height_r <= 13'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfer_pkg::REG_FACE_SIZE:   face_size_r   <= cfg_data[12:0];
        cfer_pkg::REG_PANO_WIDTH:  pano_width_r  <= cfg_data;
        cfer_pkg::REG_PANO_HEIGHT: pano_height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective sizes, width and height clamped to their limits, zero reads as one
  logic [12:0] n_eff;
  logic [13:0] w_eff;
  logic [12:0] h_eff;

  always_comb begin
    n_eff = (face_size_r == '0) ? 13'd1 : face_size_r;
    w_eff = (pano_width_r > 14'(WLIM)) ? 14'(WLIM) : pano_width_r;
    if (w_eff == '0) w_eff = 14'd1;
    h_eff = (pano_height_r > 13'd4096) ? 13'd4096 : pano_height_r;
    if (h_eff == '0) h_eff = 13'd1;
  end

  // whole pipeline advances unless the output holds an untaken transfer
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------- normalize
  logic                   div_vld;
  logic [2:0]             div_face;
  logic signed [Q_W-1:0]  qu, qv;

  cfer_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_face   (in_tdata[2:0]),
    .in_cx     (in_tdata[14:3]),
    .in_cy     (in_tdata[26:15]),
    .n         (n_eff),
    .out_valid (div_vld),
    .out_face  (div_face),
    .out_qu    (qu),
    .out_qv    (qv)
  );

  // ---------------------------------------------------------------- direction
  logic signed [VEC_W-1:0] uu, vv;
  logic signed [VEC_W-1:0] a_nxt, b_nxt, c_nxt;
  logic                    fok_nxt;
  logic signed [VEC_W-1:0] a_r, b_r, c_r;
  logic                    fok_r, vec_vld_r;

  always_comb begin
    uu      = VEC_W'($signed({qu, 8'd0}));
    vv      = VEC_W'($signed({qv, 8'd0}));
    a_nxt   = '0;
    b_nxt   = '0;
    c_nxt   = '0;
    fok_nxt = 1'b1;
    unique case (div_face)
      cfer_pkg::FACE_REAR: begin
        a_nxt = -cfer_pkg::ONE_Q24; b_nxt = -uu; c_nxt = -vv;
      end
      cfer_pkg::FACE_LEFT: begin
        a_nxt = uu; b_nxt = -cfer_pkg::ONE_Q24; c_nxt = -vv;
      end
      cfer_pkg::FACE_FRONT: begin
        a_nxt = cfer_pkg::ONE_Q24; b_nxt = uu; c_nxt = -vv;
      end
      cfer_pkg::FACE_RIGHT: begin
        a_nxt = -uu; b_nxt = cfer_pkg::ONE_Q24; c_nxt = -vv;
      end
      cfer_pkg::FACE_TOP: begin
        a_nxt = vv; b_nxt = uu; c_nxt = cfer_pkg::ONE_Q24;
      end
      cfer_pkg::FACE_BOTTOM: begin
        a_nxt = -vv; b_nxt = uu; c_nxt = -cfer_pkg::ONE_Q24;
      end
      default: fok_nxt = 1'b0;   // unused face codes give theta = phi = 0
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
      fok_r <= fok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_vld_r <= 1'b0;
    end else if (en) begin
      vec_vld_r <= div_vld;
    end
  end

  // ---------------------------------------------------------------- theta
  logic                      c1_vld;
  logic signed [ANG_W-1:0]   theta;
  logic signed [C1_W-1:0]    mag1;
  logic [VEC_W:0]            c1_side;

  cfer_cordic #(
    .STEPS  (CORDIC_STEPS),
    .W      (C1_W),
    .SIDE_W (VEC_W + 1)
  ) u_cordic_theta (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vec_vld_r),
    .in_x      (C1_W'(a_r)),
    .in_y      (C1_W'(b_r)),
    .in_side   ({fok_r, c_r}),
    .out_valid (c1_vld),
    .out_ang   (theta),
    .out_mag   (mag1),
    .out_side  (c1_side)
  );

  // ---------------------------------------------------------------- gain fix
  // z scaled by the cordic gain so it matches the gained magnitude
  logic signed [VEC_W+17:0] zg;
  logic signed [C2_W-1:0]   gx_r, gy_r;
  logic signed [ANG_W-1:0]  th_r;
  logic                     fok2_r, g_vld_r;

  assign zg = $signed(c1_side[VEC_W-1:0]) * cfer_pkg::GAIN_Q16;

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r   <= C2_W'($signed(zg[VEC_W+17:16]));
      gy_r   <= C2_W'(mag1);
      th_r   <= theta;
      fok2_r <= c1_side[VEC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r <= c1_vld;
    end
  end

  // ---------------------------------------------------------------- phi
  logic                    c2_vld;
  logic signed [ANG_W-1:0] phi;
  logic signed [C2_W-1:0]  mag2;
  logic [ANG_W:0]          c2_side;

  cfer_cordic #(
    .STEPS  (CORDIC_STEPS),
    .W      (C2_W),
    .SIDE_W (ANG_W + 1)
  ) u_cordic_phi (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_vld_r),
    .in_x      (gx_r),
    .in_y      (gy_r),
    .in_side   ({fok2_r, th_r}),
    .out_valid (c2_vld),
    .out_ang   (phi),
    .out_mag   (mag2),
    .out_side  (c2_side)
  );

  // magnitude of the second rotation is not needed; its parity is masked off in the face check
  logic unused_mag2;
  assign unused_mag2 = ^mag2;

  // ---------------------------------------------------------------- pixel
  logic [12:0] px;
  logic [11:0] py;
  logic [24:0] pidx;

  cfer_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (c2_vld),
    .in_face_ok (c2_side[ANG_W] & ~(unused_mag2 & 1'b0)),
    .in_theta   (c2_side[ANG_W-1:0]),
    .in_phi     (phi),
    .w          (w_eff),
    .h          (h_eff),
    .out_valid  (out_tvalid),
    .out_px     (px),
    .out_py     (py),
    .out_idx    (pidx)
  );

  assign out_tdata = {6'd0, pidx, py, px};

  // ---------------------------------------------------------------- checks
  `CFER_ASSERT_NEXT_RST(a_rst_clears_out, !rst_n, !out_tvalid, "output valid after reset")
  `CFER_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vec_vld_r) && $stable(g_vld_r),
    "pipeline moved during stall")
  `CFER_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, u_div.vld_r[0],
    "accepted transfer did not enter the pipeline")

endmodule
